// ----- hdl/mma_pkg.sv -----
package mma_pkg;

  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned SAMPLE_W  = 10;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] out_channel;
    logic [SAMPLE_W-1:0]  average;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_STATE,
    ST_RD_RING,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic rd_state;
    logic rd_ring;
    logic update;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/multichannel_moving_average_core.sv -----
// flow: a beat is captured in IDLE, then passes RD_STATE, RD_RING, UPDATE, DIVIDE
// and FINISH into the output register; channels out of range skip to FINISH
// a new beat is taken only in IDLE; the divider makes one quotient bit per cycle
// reset: asynchronous active low; clears channel valid bits and handshake state,
// so no memory clearing pass is needed
module multichannel_moving_average_core
  import mma_pkg::*;
#(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned CHANNELS    = 11,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  mma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mma_dp #(
    .WINDOW      (WINDOW),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/mma_ctrl.sv -----
module mma_ctrl
  import mma_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RD_STATE;
      end
      ST_RD_STATE: begin
        state_d = status_i.in_range ? ST_RD_RING : ST_FINISH;
      end
      ST_RD_RING: state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status_i.div_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_RD_STATE: cmd_o.rd_state = 1'b1;
      ST_RD_RING:  cmd_o.rd_ring  = 1'b1;
      ST_UPDATE:   cmd_o.update   = 1'b1;
      ST_DIVIDE:   cmd_o.div_step = 1'b1;
      ST_FINISH:   cmd_o.out_load = status_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/mma_dp.sv -----
module mma_dp
  import mma_pkg::*;
#(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned CHANNELS    = 11,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned SW         = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int unsigned SUM_W      = SW + $clog2(WINDOW);
  localparam int unsigned POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W     = $clog2(WINDOW + 1);
  localparam int unsigned CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RING_DEPTH = CHANNELS * WINDOW;
  localparam int unsigned RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned ST_W       = SUM_W + POS_W + FILL_W;
  localparam int unsigned CNT_W      = $clog2(SUM_W + 1);

  // per-channel state and sample rings
  logic [ST_W-1:0]   st_mem [CHANNELS];
  logic [SW-1:0]     ring_mem [RING_DEPTH];
  logic [CHANNELS-1:0] vld_q;

  logic [CHANNEL_W-1:0] ch_q;
  logic [SW-1:0]        smp_q;
  logic [ST_W-1:0]      st_rd_q;
  logic [SW-1:0]        ring_rd_q;

  logic [CH_AW-1:0]   ch_idx;
  logic               in_range;
  logic [SUM_W-1:0]   sum_cur, sum_new;
  logic [POS_W-1:0]   pos_cur, pos_new;
  logic [FILL_W-1:0]  fill_cur, fill_new;
  logic [SW-1:0]      old_smp;
  logic [RING_AW-1:0] ring_addr;

  // divider
  logic [SUM_W-1:0]  dq_q, dq_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic [FILL_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FILL_W:0]   trial;

  logic      out_valid_q;
  out_item_t out_data_q;

  assign ch_idx   = CH_AW'(ch_q);
  assign in_range = 32'(ch_q) < CHANNELS;

  assign sum_cur  = vld_q[ch_idx] ? st_rd_q[ST_W-1 -: SUM_W] : '0;
  assign pos_cur  = vld_q[ch_idx] ? st_rd_q[FILL_W +: POS_W] : '0;
  assign fill_cur = vld_q[ch_idx] ? st_rd_q[FILL_W-1:0] : '0;

  // until the ring is full the slot at the write position was never written
  assign old_smp  = (32'(fill_cur) < WINDOW) ? '0 : ring_rd_q;
  assign sum_new  = SUM_W'(sum_cur - SUM_W'(old_smp) + SUM_W'(smp_q));
  assign pos_new  = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : POS_W'(pos_cur + 1'b1);
  assign fill_new = (32'(fill_cur) < WINDOW) ? FILL_W'(fill_cur + 1'b1) : fill_cur;
  assign ring_addr = RING_AW'(32'(ch_idx) * WINDOW + 32'(pos_cur));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q  <= in_data_i.channel;
      smp_q <= in_data_i.sample[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_state) begin
      st_rd_q <= st_mem[ch_idx];
    end
    if (cmd_i.update) begin
      st_mem[ch_idx] <= {sum_new, pos_new, fill_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_ring) begin
      ring_rd_q <= ring_mem[ring_addr];
    end
    if (cmd_i.update) begin
      ring_mem[ring_addr] <= smp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.update) begin
      vld_q[ch_idx] <= 1'b1;
    end
  end

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dq_q[SUM_W-1]};

  always_comb begin
    dq_d  = {dq_q[SUM_W-2:0], 1'b0};
    rem_d = trial[FILL_W-1:0];
    if (trial >= {1'b0, dvs_q}) begin
      dq_d[0] = 1'b1;
      rem_d   = FILL_W'(trial - {1'b0, dvs_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      dq_q  <= sum_new;
      rem_q <= '0;
      dvs_q <= fill_new;
      cnt_q <= CNT_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
      cnt_q <= CNT_W'(cnt_q - 1'b1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.out_channel <= ch_q;
      out_data_q.average     <= in_range ? SAMPLE_W'(dq_q[SW-1:0]) : '0;
    end
  end

  assign status_o.in_range = in_range;
  assign status_o.div_last = (cnt_q == CNT_W'(1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
